### rtl/ckbu_pkg.sv
// ----------------------------------------------------------------------------
// ckbu_pkg
// Types and constants shared by the checked 7/9-bit field unpacker.
// ----------------------------------------------------------------------------
package ckbu_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int ACC_W = 16;
   localparam int HELD_W = 5;
   localparam int CNT_W = 11;
   localparam int ELEM_W = 9;
   localparam int LEN_W = $clog2(MAX_ELEMENTS + 1);
   localparam int CMP_W = ((LEN_W > CNT_W) ? LEN_W : CNT_W) + 1;

   typedef logic [ACC_W-1:0] acc_type;
   typedef logic [HELD_W-1:0] held_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [ELEM_W-1:0] elem_type;
   typedef logic [CMP_W-1:0] cmp_type;

   localparam cmp_type MAX_LEN = cmp_type'(MAX_ELEMENTS);
   localparam held_type WIDTH_7 = 5'd7;
   localparam held_type WIDTH_9 = 5'd9;
   localparam elem_type MASK_7 = 9'h07F;
   localparam elem_type MASK_9 = 9'h1FF;
   localparam held_type HELD_MAX = 5'd16;
   localparam held_type BYTE_BITS = 5'd8;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_PAD   = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_WIDTH_MODE    = 2'd0,
      CSR_ELEMENT_COUNT = 2'd1,
      CSR_UPPER_BOUND   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic     width_mode;
      cnt_type  element_count;
      elem_type upper_bound;
   } cfg_type;

   typedef struct packed {
      acc_type  acc;
      held_type held;
      cnt_type  done;
      logic     range_ok;
   } frame_type;

   typedef struct packed {
      elem_type   element;
      logic       last;
      status_type status;
      frame_type  next;
   } extract_type;

endpackage

### rtl/ckbu_csr.sv
// ----------------------------------------------------------------------------
// ckbu_csr
// Configuration registers: element width, element count and upper bound.
// ----------------------------------------------------------------------------
module ckbu_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_addr,
   input  logic [10:0]           csr_wr_data,
   output ckbu_pkg::cfg_type     cfg
);

   ckbu_pkg::cfg_type cfg_ff;
   ckbu_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (ckbu_pkg::csr_index_type'(csr_addr))
            ckbu_pkg::CSR_WIDTH_MODE: begin
               cfg_in.width_mode = csr_wr_data[0];
            end
            ckbu_pkg::CSR_ELEMENT_COUNT: begin
               cfg_in.element_count = csr_wr_data;
            end
            ckbu_pkg::CSR_UPPER_BOUND: begin
               cfg_in.upper_bound = csr_wr_data[8:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_mode    <= 1'b1;
         cfg_ff.element_count <= 11'd1;
         cfg_ff.upper_bound   <= 9'h1FF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/ckbu_extract.sv
// ----------------------------------------------------------------------------
// ckbu_extract
// Takes one element from the bit accumulator, checks its range, detects the
// end of the frame with its padding check, and forms the next frame state.
// ----------------------------------------------------------------------------
module ckbu_extract (
   input  ckbu_pkg::cfg_type     cfg,
   input  ckbu_pkg::frame_type   frame,
   output ckbu_pkg::extract_type result
);

   ckbu_pkg::held_type w;
   ckbu_pkg::elem_type mask;
   ckbu_pkg::elem_type elem;
   ckbu_pkg::acc_type  acc_sh;
   ckbu_pkg::held_type held_rem;
   ckbu_pkg::acc_type  pad_mask;
   ckbu_pkg::cmp_type  cnt_x;
   ckbu_pkg::cmp_type  len;
   ckbu_pkg::cmp_type  done_p1;
   logic               range_ok_new;
   logic               pad_bad;
   logic               is_last;

   always_comb begin
      w        = cfg.width_mode ? ckbu_pkg::WIDTH_9 : ckbu_pkg::WIDTH_7;
      mask     = cfg.width_mode ? ckbu_pkg::MASK_9 : ckbu_pkg::MASK_7;
      elem     = frame.acc[8:0] & mask;
      acc_sh   = frame.acc >> w;
      held_rem = frame.held - w;
      pad_mask = ~(ckbu_pkg::acc_type'('1) << held_rem);
      pad_bad  = |(acc_sh & pad_mask);

      range_ok_new = frame.range_ok & (elem <= cfg.upper_bound);

      cnt_x = ckbu_pkg::cmp_type'(cfg.element_count);
      if (cnt_x == '0) begin
         len = ckbu_pkg::cmp_type'(1);
      end else if (cnt_x > ckbu_pkg::MAX_LEN) begin
         len = ckbu_pkg::MAX_LEN;
      end else begin
         len = cnt_x;
      end
      done_p1 = ckbu_pkg::cmp_type'(frame.done) + ckbu_pkg::cmp_type'(1);
      is_last = done_p1 >= len;

      result.element = elem;
      result.last    = is_last;
      result.status  = ckbu_pkg::ST_OK;
      if (is_last) begin
         if (pad_bad) begin
            result.status = ckbu_pkg::ST_PAD;
         end else if (!range_ok_new) begin
            result.status = ckbu_pkg::ST_RANGE;
         end
         result.next.acc      = '0;
         result.next.held     = '0;
         result.next.done     = '0;
         result.next.range_ok = 1'b1;
      end else begin
         result.next.acc      = acc_sh;
         result.next.held     = held_rem;
         result.next.done     = done_p1[ckbu_pkg::CNT_W-1:0];
         result.next.range_ok = range_ok_new;
      end
   end

endmodule

### rtl/checked_bit_field_unpacker_7_9.sv
// ----------------------------------------------------------------------------
// checked_bit_field_unpacker_7_9
// Unpacks 7-bit or 9-bit elements from a byte stream, least significant bit
// first, with a range check on every element and a padding check at frame end.
// ----------------------------------------------------------------------------
// One element leaves per cycle through the result register while the result
// side does not stall. A byte is merged into the bit accumulator in the same
// cycle as the element extraction that makes room for it, so a new byte can
// be taken while earlier bits are still being drained; a 9-bit stream takes
// one byte per cycle when the result side does not stall. The rate is set by
// the single extraction unit feeding the result register. Elements are taken
// only in response to an item, so bits left over after a change of width wait
// for the next item.
module checked_bit_field_unpacker_7_9 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [8:0]  rsp_element,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_addr,
   input  logic [10:0] csr_wr_data
);

   ckbu_pkg::cfg_type     cfg;
   ckbu_pkg::frame_type   frame_ff;
   ckbu_pkg::frame_type   frame_in;
   ckbu_pkg::frame_type   base;
   ckbu_pkg::extract_type ext;
   ckbu_pkg::held_type    w;
   logic                  have_elem;
   logic                  out_free;
   logic                  fire;
   logic                  more;
   logic                  req_take;
   logic                  busy_ff;
   logic                  busy_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   ckbu_pkg::elem_type    rsp_element_ff;
   logic                  rsp_last_ff;
   ckbu_pkg::status_type  rsp_status_ff;

   ckbu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   ckbu_extract u_extract (
      .cfg    (cfg),
      .frame  (frame_ff),
      .result (ext)
   );

   always_comb begin
      w         = cfg.width_mode ? ckbu_pkg::WIDTH_9 : ckbu_pkg::WIDTH_7;
      have_elem = busy_ff && (frame_ff.held >= w);
      out_free  = !rsp_valid_ff || rsp_ready;
      fire      = have_elem && out_free;
      base      = fire ? ext.next : frame_ff;
      more      = busy_ff && (base.held >= w);
      req_ready = !more;
      req_take  = req_valid && req_ready;

      frame_in = base;
      if (req_take) begin
         frame_in.acc  = base.acc | (ckbu_pkg::acc_type'(req_byte_in) << base.held);
         frame_in.held = base.held + ckbu_pkg::BYTE_BITS;
      end

      busy_in      = req_take || more;
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff.acc      <= '0;
         frame_ff.held     <= '0;
         frame_ff.done     <= '0;
         frame_ff.range_ok <= 1'b1;
         busy_ff           <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         frame_ff     <= frame_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_element_ff <= ext.element;
         rsp_last_ff    <= ext.last;
         rsp_status_ff  <= ext.status;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_status  = rsp_status_ff;

`ifndef ASSERT_OFF
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      frame_ff.held <= ckbu_pkg::HELD_MAX)
      else $error("bit accumulator holds more than sixteen bits");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> frame_ff.held >= ckbu_pkg::BYTE_BITS)
      else $error("accepted item did not reach the accumulator");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      fire && ext.last |=> frame_ff.done == '0 && frame_ff.range_ok)
      else $error("frame state not restarted after the last element");

   a_status_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == ckbu_pkg::ST_OK)
      else $error("status set on an item that is not last");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the checked 7/9-bit field unpacker. Bytes are
// offered with random gaps while results are taken with random stalls. Each
// accepted item updates a bit-level predictor that queues the expected
// elements, and every element leaving the block is compared field by field
// with the oldest one in that queue.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int ITEM_TARGET = 1550;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct packed {
      ckbu_pkg::elem_type   element;
      logic                 last;
      ckbu_pkg::status_type status;
   } unpacked_elem_type;

   class unpack_scoreboard;
      logic     wide;
      ckbu_pkg::cnt_type  count_reg;
      ckbu_pkg::elem_type bound;
      ckbu_pkg::acc_type  acc;
      int unsigned held;
      int unsigned done;
      logic     range_ok;
      unpacked_elem_type expected_elems[$];
      int unsigned errors;
      int unsigned checked;
      int unsigned frames;
      int unsigned pad_frames;
      int unsigned range_frames;

      function new();
         wide = 1'b1;
         count_reg = ckbu_pkg::cnt_type'(1);
         bound = ckbu_pkg::MASK_9;
         errors = 0;
         checked = 0;
         frames = 0;
         pad_frames = 0;
         range_frames = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         acc = '0;
         held = 0;
         done = 0;
         range_ok = 1'b1;
      endfunction

      function void write_reg(ckbu_pkg::csr_index_type idx, logic [10:0] data);
         case (idx)
            ckbu_pkg::CSR_WIDTH_MODE: wide = data[0];
            ckbu_pkg::CSR_ELEMENT_COUNT: count_reg = data;
            ckbu_pkg::CSR_UPPER_BOUND: bound = data[8:0];
            default: ;
         endcase
      endfunction

      function int unsigned frame_len();
         int unsigned n;
         n = count_reg;
         if (n == 0) n = 1;
         if (n > ckbu_pkg::MAX_ELEMENTS) n = ckbu_pkg::MAX_ELEMENTS;
         return n;
      endfunction

      function int unsigned elem_width();
         return wide ? int'(ckbu_pkg::WIDTH_9) : int'(ckbu_pkg::WIDTH_7);
      endfunction

      function int unsigned pending();
         return expected_elems.size();
      endfunction

      function void note_byte(logic [7:0] data);
         int unsigned work;
         int unsigned have;
         int unsigned w;
         int unsigned value;
         int produced;
         logic closing;
         ckbu_pkg::status_type st;
         unpacked_elem_type item;
         work = 32'(acc) | (32'(data) << held);
         have = held + 8;
         produced = 0;
         while (produced < 2) begin
            w = elem_width();
            if (have < w) break;
            value = work & 32'(wide ? ckbu_pkg::MASK_9 : ckbu_pkg::MASK_7);
            work = work >> w;
            have = have - w;
            if (value > 32'(bound)) range_ok = 1'b0;
            closing = (done + 1) >= frame_len();
            st = ckbu_pkg::ST_OK;
            if (closing) begin
               if ((work & ((32'd1 << have) - 1)) != 0) begin
                  st = ckbu_pkg::ST_PAD;
                  pad_frames++;
               end else if (!range_ok) begin
                  st = ckbu_pkg::ST_RANGE;
                  range_frames++;
               end
            end else begin
               done = (done + 1) & 32'h7FF;
            end
            item = unpacked_elem_type'({ckbu_pkg::elem_type'(value), closing, st});
            expected_elems.push_back(item);
            produced++;
            if (closing) begin
               frames++;
               restart_frame();
               return;
            end
         end
         acc = ckbu_pkg::acc_type'(work);
         held = have;
      endfunction

      // Bits of the next item that would count as padding if that item
      // closes the frame; zero when it does not close it.
      function logic [7:0] padding_bits();
         int unsigned pos;
         int unsigned n;
         int unsigned w;
         int unsigned shift;
         int k;
         pos = 0;
         n = done;
         for (k = 0; k < 2; k++) begin
            w = elem_width();
            if (held + 8 - pos < w) return '0;
            pos = pos + w;
            if (n + 1 >= frame_len()) begin
               shift = (pos > held) ? pos - held : 0;
               if (shift >= 8) return '0;
               return 8'(8'hFF << shift);
            end
            n++;
         end
         return '0;
      endfunction

      task report(string what);
         errors++;
         $display("ERROR at %0t: element %0d: %s", $realtime, checked, what);
      endtask

      task check_elem(unpacked_elem_type got);
         unpacked_elem_type want;
         checked++;
         if (expected_elems.size() == 0) begin
            report($sformatf("unexpected element %0h last %0b status %0d",
                             got.element, got.last, got.status));
            return;
         end
         want = expected_elems.pop_front();
         if (got.element !== want.element)
            report($sformatf("element %0h, expected %0h", got.element, want.element));
         if (got.last !== want.last)
            report($sformatf("last %0b, expected %0b", got.last, want.last));
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [8:0]  rsp_element;
   logic        rsp_last;
   logic [1:0]  rsp_status;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_addr = ckbu_pkg::CSR_WIDTH_MODE;
   logic [10:0] csr_wr_data = '0;

   logic quiet = 1'b0;
   logic hold_off_req = 1'b0;
   int unsigned sent = 0;
   unpack_scoreboard sb;

   checked_bit_field_unpacker_7_9 u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_byte_in(req_byte_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_element(rsp_element),
      .rsp_last(rsp_last),
      .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en),
      .csr_addr(csr_addr),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("Timeout with %0d items sent", sent);
      $display("FAIL checked_bit_field_unpacker_7_9");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= quiet || ($urandom_range(99) >= 25);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_elem(unpacked_elem_type'({rsp_element, rsp_last, rsp_status}));
   end

   task automatic send_byte(input logic [7:0] data);
      while (!quiet && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(data);
      sent++;
   endtask

   task automatic send_random();
      logic [7:0] data;
      int r;
      data = 8'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 55) data = data & ~sb.padding_bits();
      else if (r < 60) data = 8'h00;
      else if (r < 65) data = 8'hFF;
      send_byte(data);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input ckbu_pkg::csr_index_type idx, input logic [10:0] data);
      csr_wr_en <= 1'b1;
      csr_addr <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic apply_config(input logic wr_w, input logic w, input logic wr_c,
                               input ckbu_pkg::cnt_type c, input logic wr_b,
                               input ckbu_pkg::elem_type b);
      settle();
      if (wr_w) csr_write(ckbu_pkg::CSR_WIDTH_MODE, 11'(w));
      if (wr_c) csr_write(ckbu_pkg::CSR_ELEMENT_COUNT, c);
      if (wr_b) csr_write(ckbu_pkg::CSR_UPPER_BOUND, 11'(b));
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic wr_w;
      logic wr_c;
      logic wr_b;
      logic w;
      ckbu_pkg::cnt_type c;
      ckbu_pkg::elem_type b;
      int r;
      int n;
      int phase;
      int unsigned target;

      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Nine-bit single-element frames: full scale, zero, nonzero padding.
      send_byte(8'hFF); send_byte(8'h01);
      send_byte(8'h00); send_byte(8'h00);
      send_byte(8'h00); send_byte(8'h80);

      // A bound of zero: range error alone, then with padding set as well.
      apply_config(1'b0, 1'b0, 1'b0, '0, 1'b1, 9'h000);
      send_byte(8'h01); send_byte(8'h00);
      send_byte(8'h01); send_byte(8'h02);

      // Seven-bit elements with a count of zero, which acts as one.
      apply_config(1'b1, 1'b0, 1'b1, 11'd0, 1'b1, 9'h07F);
      send_byte(8'h7F);
      send_byte(8'hFF);

      // Eight seven-bit elements fill seven items exactly, two on the last.
      apply_config(1'b0, 1'b0, 1'b1, 11'd8, 1'b1, 9'h040);
      send_byte(8'h12); send_byte(8'h34); send_byte(8'h56); send_byte(8'h78);
      send_byte(8'h9A); send_byte(8'hBC); send_byte(8'hDE);

      // Width switched from seven to nine bits in the middle of a frame.
      apply_config(1'b0, 1'b0, 1'b1, 11'd2, 1'b1, 9'h1FF);
      send_byte(8'hAB);
      apply_config(1'b1, 1'b1, 1'b0, '0, 1'b0, '0);
      send_byte(8'hCD);

      // One full-length frame with neither side idling.
      apply_config(1'b1, 1'b0, 1'b1, 11'd2047, 1'b1,
                   ckbu_pkg::elem_type'($urandom_range(300, 511)));
      quiet = 1'b1;
      target = sb.frames + 1;
      while (sb.frames < target) send_random();
      quiet = 1'b0;

      phase = 0;
      while (sent < ITEM_TARGET) begin
         w = 1'($urandom_range(1));
         r = $urandom_range(99);
         if (r < 6) c = 11'd0;
         else if (r < 12) c = 11'd1024;
         else if (r < 16) c = 11'd2047;
         else if (r < 20) c = 11'($urandom_range(2047));
         else c = 11'($urandom_range(1, 12));
         r = $urandom_range(99);
         if (r < 10) b = 9'h000;
         else if (r < 25) b = 9'h1FF;
         else if (r < 35) b = 9'h07F;
         else b = 9'($urandom_range(511));
         if (phase == 2) begin
            apply_config(1'b1, w, 1'b1, 11'd1024, 1'b1, b);
            hold_off_req = 1'b1;
            n = 60;
         end else begin
            wr_w = $urandom_range(99) < 70;
            wr_c = $urandom_range(99) < 70;
            wr_b = $urandom_range(99) < 70;
            apply_config(wr_w, w, wr_c, c, wr_b, b);
            n = $urandom_range(6, 50);
         end
         repeat (n) send_random();
         phase++;
      end

      settle();
      $display("Sent %0d items in %0d random phases; checked %0d elements over %0d frames",
               sent, phase, sb.checked, sb.frames);
      $display("Frames closing with padding error: %0d, with range error: %0d, mismatches: %0d",
               sb.pad_frames, sb.range_frames, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS checked_bit_field_unpacker_7_9");
      end else begin
         $display("FAIL checked_bit_field_unpacker_7_9");
      end
      $finish;
   end
endmodule

### sim.f
rtl/ckbu_pkg.sv
rtl/ckbu_csr.sv
rtl/ckbu_extract.sv
rtl/checked_bit_field_unpacker_7_9.sv
tb/tb_top.sv
